// ----- design/mi3_pkg.sv -----
`timescale 1ns / 1ps

package mi3_pkg;

	typedef struct packed {
		logic neg;
		logic ovf;
	} mi3_lane_t;

endpackage

// ----- design/mi3_if.sv -----
`timescale 1ns / 1ps

interface mi3_in_if #(parameter int W = 32);
	logic valid;
	logic ready;
	logic signed [W-1:0] a00;
	logic signed [W-1:0] a01;
	logic signed [W-1:0] a02;
	logic signed [W-1:0] a10;
	logic signed [W-1:0] a11;
	logic signed [W-1:0] a12;
	logic signed [W-1:0] a20;
	logic signed [W-1:0] a21;
	logic signed [W-1:0] a22;

	modport source(output valid, a00, a01, a02, a10, a11, a12, a20, a21, a22, input ready);
	modport sink(input valid, a00, a01, a02, a10, a11, a12, a20, a21, a22, output ready);
endinterface

interface mi3_out_if #(parameter int W = 32);
	logic valid;
	logic ready;
	logic signed [W-1:0] r00;
	logic signed [W-1:0] r01;
	logic signed [W-1:0] r02;
	logic signed [W-1:0] r10;
	logic signed [W-1:0] r11;
	logic signed [W-1:0] r12;
	logic signed [W-1:0] r20;
	logic signed [W-1:0] r21;
	logic signed [W-1:0] r22;
	logic signed [W-1:0] determinant;
	logic singular;
	logic saturated;

	modport source(output valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
		determinant, singular, saturated, input ready);
	modport sink(input valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
		determinant, singular, saturated, output ready);
endinterface

// ----- design/mi3_cofactor.sv -----
`timescale 1ns / 1ps

module mi3_cofactor #(
	parameter int W = 32
) (
	input  logic                    clk,
	input  logic [4:0]              en,
	input  logic signed [W-1:0]     a [9],
	output logic signed [2*W:0]     adj [9],
	output logic signed [3*W+1:0]   det
);

	localparam int PW = 2 * W;
	localparam int AW = 2 * W + 1;
	localparam int DW = 3 * W + 2;

	logic signed [PW-1:0] t_s1 [9];
	logic signed [PW-1:0] u_s1 [9];
	logic signed [W-1:0]  c0_s1 [3];
	logic signed [AW-1:0] adj_s2 [9];
	logic signed [W-1:0]  c0_s2 [3];
	logic signed [AW-1:0] adj_s3 [9];
	logic signed [AW-1:0] lo_s3 [3];
	logic signed [AW-1:0] hi_s3 [3];
	logic signed [AW-1:0] adj_s4 [9];
	logic signed [DW-1:0] pr_s4 [3];
	logic signed [AW-1:0] adj_s5 [9];
	logic signed [DW-1:0] det_s5;

	for (genvar i = 0; i < 3; i++) begin : g_row
		for (genvar j = 0; j < 3; j++) begin : g_col
			localparam int K = j * 3 + i;
			localparam int XA = ((i + 1) % 3) * 3 + (j + 1) % 3;
			localparam int XB = ((i + 2) % 3) * 3 + (j + 2) % 3;
			localparam int YA = ((i + 1) % 3) * 3 + (j + 2) % 3;
			localparam int YB = ((i + 2) % 3) * 3 + (j + 1) % 3;
			always_ff @(posedge clk) begin
				if (en[0]) begin
					t_s1[K] <= PW'(a[XA]) * PW'(a[XB]);
					u_s1[K] <= PW'(a[YA]) * PW'(a[YB]);
				end
			end
		end
	end

	for (genvar k = 0; k < 9; k++) begin : g_adj
		always_ff @(posedge clk) begin
			if (en[1]) adj_s2[k] <= AW'(t_s1[k]) - AW'(u_s1[k]);
			if (en[2]) adj_s3[k] <= adj_s2[k];
			if (en[3]) adj_s4[k] <= adj_s3[k];
			if (en[4]) adj_s5[k] <= adj_s4[k];
		end
	end

	for (genvar i = 0; i < 3; i++) begin : g_det
		logic signed [W:0] lo;
		logic signed [W:0] hi;
		assign lo = $signed({1'b0, adj_s2[i][W-1:0]});
		assign hi = adj_s2[i][2*W:W];
		always_ff @(posedge clk) begin
			if (en[0]) c0_s1[i] <= a[i*3];
			if (en[1]) c0_s2[i] <= c0_s1[i];
			if (en[2]) begin
				lo_s3[i] <= AW'(c0_s2[i]) * AW'(lo);
				hi_s3[i] <= AW'(c0_s2[i]) * AW'(hi);
			end
			if (en[3]) pr_s4[i] <= (DW'(hi_s3[i]) <<< W) + DW'(lo_s3[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (en[4]) det_s5 <= pr_s4[0] + pr_s4[1] + pr_s4[2];
	end

	assign adj = adj_s5;
	assign det = det_s5;

endmodule

// ----- design/mi3_div_lane.sv -----
`timescale 1ns / 1ps

module mi3_div_lane import mi3_pkg::*; #(
	parameter int W = 32,
	parameter int F = 16
) (
	input  logic             clk,
	input  logic [W:0]       en,
	input  logic [2*W:0]     mag,
	input  logic [3*W+1:0]   dmag,
	input  logic             neg,
	output logic [W-1:0]     q,
	output mi3_lane_t        st
);

	localparam int AMW = 2 * W + 1;
	localparam int DW  = 3 * W + 2;
	localparam int NW  = (((AMW + 2 * F + 1) > DW) ? (AMW + 2 * F + 1) : DW) + 1;
	localparam int LW  = (NW > (DW + 1 + W)) ? NW : (DW + 1 + W);

	logic [NW-1:0] num;
	logic [LW-1:0] den;
	logic [LW-1:0] rem_s [W+1];
	logic [LW-1:0] den_s [W+1];
	logic [W-1:0]  qb_s  [W+1];
	logic          neg_s [W+1];
	logic          ovf_s [W+1];

	assign num = (NW'(mag) << (2 * F + 1)) + NW'(dmag);
	assign den = LW'({dmag, 1'b0});

	always_ff @(posedge clk) begin
		if (en[0]) begin
			rem_s[0] <= LW'(num);
			den_s[0] <= den;
			qb_s[0]  <= '0;
			neg_s[0] <= neg;
			ovf_s[0] <= LW'(num) >= (den << W);
		end
	end

	for (genvar s = 1; s <= W; s++) begin : g_stage
		localparam int B = W - s;
		logic [LW-1:0] trial;
		logic          take;
		assign trial = den_s[s-1] << B;
		assign take  = rem_s[s-1] >= trial;
		always_ff @(posedge clk) begin
			if (en[s]) begin
				rem_s[s] <= take ? rem_s[s-1] - trial : rem_s[s-1];
				qb_s[s]  <= take ? (qb_s[s-1] | (W'(1) << B)) : qb_s[s-1];
				den_s[s] <= den_s[s-1];
				neg_s[s] <= neg_s[s-1];
				ovf_s[s] <= ovf_s[s-1];
			end
		end
	end

	assign q      = qb_s[W];
	assign st.neg = neg_s[W];
	assign st.ovf = ovf_s[W];

endmodule

// ----- design/matrix_inverse_3x3.sv -----
// 3x3 matrix inverse by adjugate and determinant, signed fixed point.
// Throughput: one matrix per cycle while res.ready is held high; nine divider lanes retire one quotient bit per stage.
// Ready ripples back through full stages in the same cycle, so bubbles are squeezed out.
// Reset clears the stage valid bits only; data registers are not reset.
`timescale 1ns / 1ps

module matrix_inverse_3x3 import mi3_pkg::*; #(
	parameter int ELEM_WIDTH = 32,
	parameter int FRAC_BITS  = 16
) (
	input logic     clk,
	input logic     arst_n,
	mi3_in_if.sink  mat,
	mi3_out_if.source res
);

	localparam int W   = ELEM_WIDTH;
	localparam int F   = FRAC_BITS;
	localparam int AW  = 2 * W + 1;
	localparam int DW  = 3 * W + 2;
	localparam int NS  = W + 8;
	localparam int LS  = 6;

	logic [NS-1:0] v;
	logic [NS:0]   adv;

	logic signed [W-1:0]  a_in [9];
	logic signed [AW-1:0] adj [9];
	logic signed [DW-1:0] det;

	logic [AW-1:0] mag_s6 [9];
	logic          an_s6 [9];
	logic [DW-1:0] dmag_s6;
	logic          dneg_s6;
	logic          sing_s6;

	logic [W-1:0]  lq [9];
	mi3_lane_t     lst [9];

	logic [DW-1:0] dr_s [W+1];
	logic          dn_s [W+1];
	logic          sg_s [W+1];
	logic [DW+1:0] dround;

	logic [W-1:0]  val_c [10];
	logic          sat_c;
	logic [W-1:0]  out_q [10];
	logic          sing_q;
	logic          sat_q;

	assign a_in[0] = mat.a00;
	assign a_in[1] = mat.a01;
	assign a_in[2] = mat.a02;
	assign a_in[3] = mat.a10;
	assign a_in[4] = mat.a11;
	assign a_in[5] = mat.a12;
	assign a_in[6] = mat.a20;
	assign a_in[7] = mat.a21;
	assign a_in[8] = mat.a22;

	always_comb begin
		adv[NS] = res.ready;
		for (int k = NS - 1; k >= 0; k--) begin
			adv[k] = !v[k] || adv[k+1];
		end
	end

	assign mat.ready = adv[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v <= '0;
		end else begin
			if (adv[0]) v[0] <= mat.valid;
			for (int k = 1; k < NS; k++) begin
				if (adv[k]) v[k] <= v[k-1];
			end
		end
	end

	mi3_cofactor #(.W(W)) u_cof (
		.clk (clk),
		.en  (adv[4:0]),
		.a   (a_in),
		.adj (adj),
		.det (det)
	);

	// magnitudes and signs
	for (genvar k = 0; k < 9; k++) begin : g_abs
		always_ff @(posedge clk) begin
			if (adv[5]) begin
				mag_s6[k] <= adj[k][AW-1] ? $unsigned(-adj[k]) : $unsigned(adj[k]);
				an_s6[k]  <= adj[k][AW-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv[5]) begin
			dmag_s6 <= det[DW-1] ? $unsigned(-det) : $unsigned(det);
			dneg_s6 <= det[DW-1];
			sing_s6 <= det == '0;
		end
	end

	for (genvar k = 0; k < 9; k++) begin : g_lane
		mi3_div_lane #(.W(W), .F(F)) u_lane (
			.clk  (clk),
			.en   (adv[LS +: W+1]),
			.mag  (mag_s6[k]),
			.dmag (dmag_s6),
			.neg  (an_s6[k] ^ dneg_s6),
			.q    (lq[k]),
			.st   (lst[k])
		);
	end

	// determinant: round half away, then delay alongside the lanes
	assign dround = ({dmag_s6, 1'b0} + ((DW+2)'(1) << (2 * F))) >> (2 * F + 1);

	always_ff @(posedge clk) begin
		if (adv[LS]) begin
			dr_s[0] <= dround[DW-1:0];
			dn_s[0] <= dneg_s6;
			sg_s[0] <= sing_s6;
		end
		for (int m = 1; m <= W; m++) begin
			if (adv[LS+m]) begin
				dr_s[m] <= dr_s[m-1];
				dn_s[m] <= dn_s[m-1];
				sg_s[m] <= sg_s[m-1];
			end
		end
	end

	// merge lanes: clip, apply sign, mask on singular
	always_comb begin
		logic [W-1:0] lim;
		logic [W-1:0] mg;
		logic         st;
		logic         any;
		any = 1'b0;
		for (int k = 0; k < 9; k++) begin
			lim = lst[k].neg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
			st  = lst[k].ovf || (lq[k] > lim);
			mg  = st ? lim : lq[k];
			any = any | st;
			val_c[k] = sg_s[W] ? '0 : (lst[k].neg ? W'(-mg) : mg);
		end
		lim = dn_s[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
		st  = dr_s[W] > DW'(lim);
		mg  = st ? lim : dr_s[W][W-1:0];
		any = any | st;
		val_c[9] = sg_s[W] ? '0 : (dn_s[W] ? W'(-mg) : mg);
		sat_c = any && !sg_s[W];
	end

	always_ff @(posedge clk) begin
		if (adv[NS-1]) begin
			out_q  <= val_c;
			sing_q <= sg_s[W];
			sat_q  <= sat_c;
		end
	end

	assign res.valid       = v[NS-1];
	assign res.r00         = out_q[0];
	assign res.r01         = out_q[1];
	assign res.r02         = out_q[2];
	assign res.r10         = out_q[3];
	assign res.r11         = out_q[4];
	assign res.r12         = out_q[5];
	assign res.r20         = out_q[6];
	assign res.r21         = out_q[7];
	assign res.r22         = out_q[8];
	assign res.determinant = out_q[9];
	assign res.singular    = sing_q;
	assign res.saturated   = sat_q;

`ifndef ASSERT_OFF
	a_singular_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.singular |-> res.determinant == '0 && !res.saturated
			&& res.r00 == '0 && res.r11 == '0 && res.r22 == '0)
		else $error("singular result carries nonzero data");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!res.valid |-> mat.ready)
		else $error("input stalled with empty output stage");

	a_take_word: assert property (@(posedge clk) disable iff (!arst_n)
		mat.valid && mat.ready |=> v[0])
		else $error("accepted word not captured in first stage");
`endif

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
	import mi3_pkg::*;

	localparam int W          = 32;
	localparam int FRAC       = 16;
	localparam int N_RANDOM   = 1900;
	localparam int QUIET_FROM = 1650;
	localparam int LATENCY    = W + 8;
	localparam int LIMIT      = 200000;

	typedef logic signed [255:0] big_t;

	typedef struct {
		logic signed [W-1:0] e [9];
	} matrix_t;

	typedef struct {
		logic signed [W-1:0] v [10];
		logic                singular;
		logic                saturated;
	} inverse_t;

	class inverse_board;
		inverse_t pending [$];
		int       errors;
		int       checked;
		int       singular_seen;
		int       saturated_seen;

		function big_t div_round(big_t n, big_t d);
			big_t mn, md, q;
			mn = (n < 0) ? -n : n;
			md = (d < 0) ? -d : d;
			q  = (2 * mn + md) / (2 * md);
			return ((n < 0) != (d < 0)) ? -q : q;
		endfunction

		function logic signed [W-1:0] clip(big_t x, ref logic sat);
			big_t hi, lo;
			hi = (big_t'(1) <<< (W - 1)) - 1;
			lo = -(big_t'(1) <<< (W - 1));
			if (x > hi) begin
				sat = 1'b1;
				return hi[W-1:0];
			end
			if (x < lo) begin
				sat = 1'b1;
				return lo[W-1:0];
			end
			return x[W-1:0];
		endfunction

		function void note(matrix_t m);
			big_t     a [3][3];
			big_t     adj [3][3];
			big_t     det;
			inverse_t r;
			logic     sat;
			for (int i = 0; i < 3; i++)
				for (int j = 0; j < 3; j++)
					a[i][j] = m.e[i * 3 + j];
			for (int i = 0; i < 3; i++)
				for (int j = 0; j < 3; j++)
					adj[j][i] = a[(i + 1) % 3][(j + 1) % 3] * a[(i + 2) % 3][(j + 2) % 3]
						- a[(i + 1) % 3][(j + 2) % 3] * a[(i + 2) % 3][(j + 1) % 3];
			det = 0;
			for (int i = 0; i < 3; i++)
				det += a[i][0] * adj[0][i];
			sat = 1'b0;
			if (det == 0) begin
				foreach (r.v[k]) r.v[k] = '0;
				r.singular  = 1'b1;
				r.saturated = 1'b0;
			end else begin
				for (int i = 0; i < 3; i++)
					for (int j = 0; j < 3; j++)
						r.v[i * 3 + j] = clip(div_round(adj[i][j] <<< (2 * FRAC), det), sat);
				r.v[9]      = clip(div_round(det, big_t'(1) <<< (2 * FRAC)), sat);
				r.singular  = 1'b0;
				r.saturated = sat;
			end
			pending.push_back(r);
		endfunction

		function void check(inverse_t got);
			inverse_t exp_r;
			string    names [10] = '{"r00", "r01", "r02", "r10", "r11", "r12",
				"r20", "r21", "r22", "determinant"};
			if (pending.size() == 0) begin
				$display("%0t: unexpected result word, nothing pending", $time);
				errors++;
				return;
			end
			exp_r = pending.pop_front();
			checked++;
			if (exp_r.singular) singular_seen++;
			if (exp_r.saturated) saturated_seen++;
			for (int k = 0; k < 10; k++)
				if (got.v[k] !== exp_r.v[k]) begin
					$display("%0t: %s expected %h actual %h", $time, names[k],
						exp_r.v[k], got.v[k]);
					errors++;
				end
			if (got.singular !== exp_r.singular) begin
				$display("%0t: singular expected %b actual %b", $time,
					exp_r.singular, got.singular);
				errors++;
			end
			if (got.saturated !== exp_r.saturated) begin
				$display("%0t: saturated expected %b actual %b", $time,
					exp_r.saturated, got.saturated);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	bit   quiet = 1'b0;
	int   cycles = 0;
	int   sent = 0;

	mi3_in_if  #(W) mat_bus ();
	mi3_out_if #(W) res_bus ();

	matrix_inverse_3x3 #(.ELEM_WIDTH(W), .FRAC_BITS(FRAC)) i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.mat   (mat_bus),
		.res   (res_bus)
	);

	inverse_board board = new();

	always #5 clk = ~clk;

	initial begin
		mat_bus.valid = 1'b0;
		{mat_bus.a00, mat_bus.a01, mat_bus.a02} = '0;
		{mat_bus.a10, mat_bus.a11, mat_bus.a12} = '0;
		{mat_bus.a20, mat_bus.a21, mat_bus.a22} = '0;
		res_bus.ready = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("%0t: run exceeded cycle limit", $time);
			$display("matrix_inverse_3x3: mismatch");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && mat_bus.valid && mat_bus.ready) begin
			matrix_t m;
			m.e = '{mat_bus.a00, mat_bus.a01, mat_bus.a02, mat_bus.a10, mat_bus.a11,
				mat_bus.a12, mat_bus.a20, mat_bus.a21, mat_bus.a22};
			board.note(m);
		end
	end

	always @(posedge clk) begin
		if (arst_n && res_bus.valid && res_bus.ready) begin
			inverse_t got;
			got.v = '{res_bus.r00, res_bus.r01, res_bus.r02, res_bus.r10, res_bus.r11,
				res_bus.r12, res_bus.r20, res_bus.r21, res_bus.r22, res_bus.determinant};
			got.singular  = res_bus.singular;
			got.saturated = res_bus.saturated;
			board.check(got);
		end
	end

	initial begin
		int n;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if (!quiet && $urandom_range(0, 3) == 0) begin
				n = $urandom_range(1, 7);
				res_bus.ready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			res_bus.ready <= 1'b1;
			@(posedge clk);
		end
	end

	function automatic logic signed [W-1:0] small_val(int span);
		return $signed($urandom_range(0, 2 * span)) - span;
	endfunction

	function automatic matrix_t make_matrix(int kind);
		matrix_t m;
		int      span;
		span = (1 << $urandom_range(12, 20));
		for (int k = 0; k < 9; k++) begin
			case (kind)
				0:       m.e[k] = $urandom;
				1, 2:    m.e[k] = small_val(span);
				3:       m.e[k] = ($urandom_range(0, 1)) ? $urandom : small_val(span);
				default: m.e[k] = small_val(4);
			endcase
		end
		if (kind == 2) begin
			case ($urandom_range(0, 2))
				0: for (int c = 0; c < 3; c++) m.e[6 + c] = m.e[c];
				1: for (int r = 0; r < 3; r++) m.e[r * 3 + 1] = '0;
				default: for (int c = 0; c < 3; c++) m.e[3 + c] = -m.e[c];
			endcase
		end
		return m;
	endfunction

	task automatic send_matrix(matrix_t m);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			mat_bus.valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		mat_bus.valid <= 1'b1;
		{mat_bus.a00, mat_bus.a01, mat_bus.a02} <= {m.e[0], m.e[1], m.e[2]};
		{mat_bus.a10, mat_bus.a11, mat_bus.a12} <= {m.e[3], m.e[4], m.e[5]};
		{mat_bus.a20, mat_bus.a21, mat_bus.a22} <= {m.e[6], m.e[7], m.e[8]};
		do @(posedge clk); while (!mat_bus.ready);
		sent++;
	endtask

	task automatic send_diag(logic signed [W-1:0] d0, logic signed [W-1:0] d1,
			logic signed [W-1:0] d2);
		matrix_t m;
		foreach (m.e[k]) m.e[k] = '0;
		m.e[0] = d0;
		m.e[4] = d1;
		m.e[8] = d2;
		send_matrix(m);
	endtask

	task automatic send_fill(logic signed [W-1:0] x);
		matrix_t m;
		foreach (m.e[k]) m.e[k] = x;
		send_matrix(m);
	endtask

	initial begin
		matrix_t m;
		int      wait_cycles;
		localparam logic signed [W-1:0] ONE  = 1 << FRAC;
		localparam logic signed [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
		localparam logic signed [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_diag(ONE, ONE, ONE);
		send_diag(-ONE, 2 * ONE, ONE / 2);
		send_fill('0);
		send_fill(ONE);
		send_fill(MAXV);
		send_fill(MINV);
		send_diag(MAXV, MAXV, MAXV);
		send_diag(MINV, MINV, MINV);
		send_diag(MINV, MAXV, MINV);
		send_diag(1, 1, 1);
		send_diag(-1, 1, 1);
		send_diag(ONE, ONE, 1);
		send_diag(3, ONE, ONE);
		send_diag(ONE / 3, ONE / 7, 3 * ONE);
		send_diag(32'sh7fff_0000, 32'sh0001_0000, 32'sh0000_8000);
		m.e = '{ONE, 2 * ONE, 3 * ONE, 4 * ONE, 5 * ONE, 6 * ONE, 7 * ONE, 8 * ONE, 10 * ONE};
		send_matrix(m);
		m.e = '{'0, ONE, '0, '0, '0, ONE, ONE, '0, '0};
		send_matrix(m);
		m.e = '{MAXV, MINV, MAXV, MINV, MAXV, MINV, MAXV, MINV, '0};
		send_matrix(m);
		m.e = '{MINV, MAXV, 1, -1, MINV, MAXV, MAXV, 1, MINV};
		send_matrix(m);
		m.e = '{2, 3, 5, 7, 11, 13, 17, 19, 23};
		send_matrix(m);

		for (int i = 0; i < N_RANDOM; i++) begin
			int pick;
			if (i >= QUIET_FROM) quiet = 1'b1;
			pick = $urandom_range(0, 99);
			if (pick < 25)      m = make_matrix(0);
			else if (pick < 65) m = make_matrix(1);
			else if (pick < 78) m = make_matrix(2);
			else if (pick < 92) m = make_matrix(3);
			else                m = make_matrix(4);
			send_matrix(m);
		end
		mat_bus.valid <= 1'b0;

		while (board.pending.size() != 0) @(posedge clk);
		wait_cycles = 0;
		while (wait_cycles < LATENCY + 20) begin
			@(posedge clk);
			wait_cycles++;
		end

		$display("sent %0d matrices, checked %0d inverses", sent, board.checked);
		$display("  %0d singular, %0d with clipped outputs, %0d errors",
			board.singular_seen, board.saturated_seen, board.errors);
		if (board.errors == 0 && board.pending.size() == 0)
			$display("matrix_inverse_3x3: match");
		else
			$display("matrix_inverse_3x3: mismatch");
		$finish;
	end

endmodule
